[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands for the palette block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed: invariant");

// cons holds in the same cycle as ante
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[src/wgp_pkg.sv]
// ----------------------------------------------------------------------------
// wgp_pkg
// Shared types and codes of the weighted gradient palette.
// ----------------------------------------------------------------------------
`default_nettype none

package wgp_pkg;

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_ADD    = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_RANGE   = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   localparam int         CSR_WIDTH          = 11;
   localparam logic [10:0] PALETTE_SIZE_RESET = 11'd256;
   localparam int         INDEX_WIDTH        = 10;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] weight;
   } entry_type;

   typedef struct packed {
      logic       load_req;
      logic       clear;
      logic       add;
      logic       set_status;
      logic [1:0] status_code;
      logic       sum_init;
      logic       sum_step;
      logic       seg_init;
      logic       den_load;
      logic       div_len_start;
      logic       seg_next;
      logic       j_load;
      logic       jt_load;
      logic       ch_prod;
      logic       div_ch_start;
      logic       ch_store;
      logic       publish;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       full;
      logic       few;
      logic       total_zero;
      logic       last;
      logic       hit;
      logic       div_done;
      logic       ch_last;
   } sts_type;

endpackage

`default_nettype wire

[src/wgp_divider.sv]
// ----------------------------------------------------------------------------
// wgp_divider
// Restoring divider, one quotient bit per cycle, quotient below 2**QB.
// ----------------------------------------------------------------------------
`default_nettype none

module wgp_divider #(
   parameter int NW = 31,
   parameter int DW = 19,
   parameter int QB = 11
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic [QB-1:0]      quot,
   output logic               rem_nz
);

   localparam int XW = (NW > DW + QB) ? NW : DW + QB;
   localparam int CW = $clog2(QB + 1);

   logic [XW-1:0] rem_ff;
   logic [XW-1:0] dvs_ff;
   logic [QB-1:0] quot_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic          ge;

   assign ge = (rem_ff >= dvs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(QB);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= XW'(num);
         dvs_ff  <= XW'(den) << (QB - 1);
         quot_ff <= '0;
      end else if (busy_ff) begin
         if (ge) begin
            rem_ff <= rem_ff - dvs_ff;
         end
         quot_ff <= {quot_ff[QB-2:0], ge};
         dvs_ff  <= dvs_ff >> 1;
      end
   end

   assign done   = done_ff;
   assign quot   = quot_ff;
   assign rem_nz = (rem_ff != '0);

endmodule

`default_nettype wire

[src/wgp_datapath.sv]
// ----------------------------------------------------------------------------
// wgp_datapath
// Stop table, size register, segment walk, blend arithmetic, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module wgp_datapath
   import wgp_pkg::*;
#(
   parameter int MAX_STOPS   = 8,
   parameter int MAX_PALETTE = 1024
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output sts_type                     sts,
   input  wire logic [1:0]             req_kind,
   input  wire logic [7:0]             req_red,
   input  wire logic [7:0]             req_green,
   input  wire logic [7:0]             req_blue,
   input  wire logic [7:0]             req_stop_weight,
   input  wire logic [INDEX_WIDTH-1:0] req_index,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_WIDTH-1:0]   csr_wr_data,
   output logic [7:0]                  rsp_out_red,
   output logic [7:0]                  rsp_out_green,
   output logic [7:0]                  rsp_out_blue,
   output logic [1:0]                  rsp_status
);

   localparam int IW   = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
   localparam int CNW  = $clog2(MAX_STOPS + 1);
   localparam int SW   = $clog2(MAX_PALETTE + 1);
   localparam int TW   = 8 + CNW;
   localparam int DENW = 8 + SW;
   localparam int NW   = SW + TW + 8;
   localparam int QB   = (SW > 8) ? SW : 8;
   localparam int EW   = (SW + 1 > INDEX_WIDTH) ? SW + 1 : INDEX_WIDTH;
   localparam int ZW   = (SW > CSR_WIDTH) ? SW : CSR_WIDTH;

   entry_type              stop_ff [MAX_STOPS];
   logic [CNW-1:0]         count_ff;
   logic [CSR_WIDTH-1:0]   size_ff;
   logic [1:0]             kind_ff;
   entry_type              req_entry_ff;
   logic [INDEX_WIDTH-1:0] index_ff;
   logic [IW-1:0]          seg_ff;
   logic [TW-1:0]          total_ff;
   entry_type              cur_ff;
   logic [SW-1:0]          start_ff;
   logic [DENW-1:0]        den_ff;
   logic [SW-1:0]          j_ff;
   logic [SW+TW-1:0]       jt_ff;
   logic [NW-1:0]          n_ff;
   logic                   neg_ff;
   logic [1:0]             ch_ff;
   logic [7:0]             stg_red_ff;
   logic [7:0]             stg_green_ff;
   logic [7:0]             stg_blue_ff;
   logic [1:0]             stg_status_ff;
   logic [7:0]             out_red_ff;
   logic [7:0]             out_green_ff;
   logic [7:0]             out_blue_ff;
   logic [1:0]             out_status_ff;

   logic [ZW-1:0]          size_ext;
   logic [SW-1:0]          size_sat;
   logic                   last;
   logic [IW-1:0]          nxt_idx;
   logic [IW-1:0]          rd_addr;
   entry_type              rd_entry;
   logic [SW-1:0]          len;
   logic [7:0]             c1;
   logic [7:0]             c2;
   logic [7:0]             mag;
   logic [7:0]             blend_val;
   logic                   div_start;
   logic [NW-1:0]          div_num;
   logic [DENW-1:0]        div_den;
   logic                   div_done;
   logic [QB-1:0]          div_quot;
   logic                   div_rem_nz;

   assign size_ext = ZW'(size_ff);
   assign size_sat = (size_ext > ZW'(MAX_PALETTE)) ? SW'(MAX_PALETTE) : SW'(size_ext);
   assign last     = ((CNW'(seg_ff) + CNW'(1)) == count_ff);
   assign nxt_idx  = last ? '0 : seg_ff + IW'(1);
   assign rd_addr  = cmd.sum_step ? seg_ff : nxt_idx;
   assign rd_entry = stop_ff[rd_addr];
   assign len      = SW'(div_quot);

   always_comb begin
      case (ch_ff)
         CH_RED: begin
            c1 = cur_ff.red;
            c2 = rd_entry.red;
         end
         CH_GREEN: begin
            c1 = cur_ff.green;
            c2 = rd_entry.green;
         end
         default: begin
            c1 = cur_ff.blue;
            c2 = rd_entry.blue;
         end
      endcase
      mag = (c2 >= c1) ? c2 - c1 : c1 - c2;
      if (neg_ff) begin
         blend_val = c1 - div_quot[7:0] - {7'd0, div_rem_nz};
      end else begin
         blend_val = c1 + div_quot[7:0];
      end
   end

   assign div_start = cmd.div_len_start | cmd.div_ch_start;
   assign div_num   = cmd.div_len_start ? NW'(den_ff) : n_ff;
   assign div_den   = cmd.div_len_start ? DENW'(total_ff) : den_ff;

   wgp_divider #(
      .NW (NW),
      .DW (DENW),
      .QB (QB)
   ) u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .done   (div_done),
      .quot   (div_quot),
      .rem_nz (div_rem_nz)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         size_ff  <= PALETTE_SIZE_RESET;
      end else begin
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
         if (cmd.clear) begin
            count_ff <= '0;
         end else if (cmd.add) begin
            count_ff <= count_ff + CNW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add) begin
         stop_ff[count_ff[IW-1:0]] <= req_entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff             <= req_kind;
         req_entry_ff.red    <= req_red;
         req_entry_ff.green  <= req_green;
         req_entry_ff.blue   <= req_blue;
         req_entry_ff.weight <= req_stop_weight;
         index_ff            <= req_index;
         stg_red_ff          <= '0;
         stg_green_ff        <= '0;
         stg_blue_ff         <= '0;
         stg_status_ff       <= STATUS_OK;
      end
      if (cmd.set_status) begin
         stg_status_ff <= cmd.status_code;
      end
      if (cmd.sum_init) begin
         total_ff <= '0;
         seg_ff   <= '0;
      end
      if (cmd.sum_step) begin
         total_ff <= total_ff + TW'(rd_entry.weight);
         seg_ff   <= seg_ff + IW'(1);
         if (seg_ff == '0) begin
            cur_ff <= rd_entry;
         end
      end
      if (cmd.seg_init) begin
         seg_ff   <= '0;
         start_ff <= '0;
      end
      if (cmd.den_load) begin
         den_ff <= DENW'(cur_ff.weight) * DENW'(size_sat);
      end
      if (cmd.seg_next) begin
         start_ff <= start_ff + len;
         seg_ff   <= seg_ff + IW'(1);
         cur_ff   <= rd_entry;
      end
      if (cmd.j_load) begin
         j_ff  <= SW'(EW'(index_ff) - EW'(start_ff));
         ch_ff <= CH_RED;
      end
      if (cmd.jt_load) begin
         jt_ff <= (SW+TW)'(j_ff) * (SW+TW)'(total_ff);
      end
      if (cmd.ch_prod) begin
         n_ff   <= NW'(jt_ff) * NW'(mag);
         neg_ff <= (c2 < c1);
      end
      if (cmd.ch_store) begin
         case (ch_ff)
            CH_RED:   stg_red_ff   <= blend_val;
            CH_GREEN: stg_green_ff <= blend_val;
            default:  stg_blue_ff  <= blend_val;
         endcase
         ch_ff <= ch_ff + 2'd1;
      end
      if (cmd.publish) begin
         out_red_ff    <= stg_red_ff;
         out_green_ff  <= stg_green_ff;
         out_blue_ff   <= stg_blue_ff;
         out_status_ff <= stg_status_ff;
      end
   end

   always_comb begin
      sts.kind       = kind_ff;
      sts.full       = (count_ff == CNW'(MAX_STOPS));
      sts.few        = (count_ff < CNW'(2));
      sts.total_zero = (total_ff == '0);
      sts.last       = last;
      sts.hit        = (len != '0) && (EW'(index_ff) < EW'(start_ff) + EW'(len));
      sts.div_done   = div_done;
      sts.ch_last    = (ch_ff == CH_BLUE);
   end

   assign rsp_out_red   = out_red_ff;
   assign rsp_out_green = out_green_ff;
   assign rsp_out_blue  = out_blue_ff;
   assign rsp_status    = out_status_ff;

endmodule

`default_nettype wire

[src/wgp_ctrl.sv]
// ----------------------------------------------------------------------------
// wgp_ctrl
// Sequencer: decode, weight sum, segment walk, per-channel blend, output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module wgp_ctrl
   import wgp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_SUM    = 4'd2;
   localparam logic [3:0] S_CHECK  = 4'd3;
   localparam logic [3:0] S_LEN    = 4'd4;
   localparam logic [3:0] S_LDIV   = 4'd5;
   localparam logic [3:0] S_LWAIT  = 4'd6;
   localparam logic [3:0] S_TEST   = 4'd7;
   localparam logic [3:0] S_JT     = 4'd8;
   localparam logic [3:0] S_CPROD  = 4'd9;
   localparam logic [3:0] S_CDIV   = 4'd10;
   localparam logic [3:0] S_CWAIT  = 4'd11;
   localparam logic [3:0] S_OUT    = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_OUT;
            unique case (sts.kind)
               KIND_CLEAR: cmd.clear = 1'b1;
               KIND_ADD: begin
                  if (sts.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_FULL;
                  end else begin
                     cmd.add = 1'b1;
                  end
               end
               KIND_LOOKUP: begin
                  if (sts.few) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_INVALID;
                  end else begin
                     cmd.sum_init = 1'b1;
                     state_in     = S_SUM;
                  end
               end
               default: ;
            endcase
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            if (sts.last) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.total_zero) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_INVALID;
               state_in        = S_OUT;
            end else begin
               cmd.seg_init = 1'b1;
               state_in     = S_LEN;
            end
         end
         S_LEN: begin
            cmd.den_load = 1'b1;
            state_in     = S_LDIV;
         end
         S_LDIV: begin
            cmd.div_len_start = 1'b1;
            state_in          = S_LWAIT;
         end
         S_LWAIT: begin
            if (sts.div_done) begin
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            if (sts.hit) begin
               cmd.j_load = 1'b1;
               state_in   = S_JT;
            end else if (sts.last) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_RANGE;
               state_in        = S_OUT;
            end else begin
               cmd.seg_next = 1'b1;
               state_in     = S_LEN;
            end
         end
         S_JT: begin
            cmd.jt_load = 1'b1;
            state_in    = S_CPROD;
         end
         S_CPROD: begin
            cmd.ch_prod = 1'b1;
            state_in    = S_CDIV;
         end
         S_CDIV: begin
            cmd.div_ch_start = 1'b1;
            state_in         = S_CWAIT;
         end
         S_CWAIT: begin
            if (sts.div_done) begin
               cmd.ch_store = 1'b1;
               state_in     = sts.ch_last ? S_OUT : S_CPROD;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

[src/weighted_gradient_palette_top.sv]
// ----------------------------------------------------------------------------
// weighted_gradient_palette_top
// Cyclic weighted RGB gradient palette with exact integer segment blending.
// ----------------------------------------------------------------------------
// One transaction at a time. Clear, add and undefined kinds go from decode
// straight to the output slot. A lookup sums the weights of all stops, then
// walks the segments up to the one that holds the index and blends there:
// a shared one-bit-per-cycle divider forms each segment length and each of
// the three channel quotients in turn, each of QB bits, QB being the size
// width in bits (11 at the default depth, at least 8). A new request is
// taken while the previous result still waits in the output register.
`default_nettype none
`include "assert_macros.svh"

module weighted_gradient_palette_top
   import wgp_pkg::*;
#(
   parameter int MAX_STOPS   = 8,
   parameter int MAX_PALETTE = 1024
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_kind,
   input  wire logic [7:0]             req_red,
   input  wire logic [7:0]             req_green,
   input  wire logic [7:0]             req_blue,
   input  wire logic [7:0]             req_stop_weight,
   input  wire logic [INDEX_WIDTH-1:0] req_index,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_out_red,
   output logic [7:0]                  rsp_out_green,
   output logic [7:0]                  rsp_out_blue,
   output logic [1:0]                  rsp_status,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_WIDTH-1:0]   csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   wgp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   wgp_datapath #(
      .MAX_STOPS   (MAX_STOPS),
      .MAX_PALETTE (MAX_PALETTE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_kind        (req_kind),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_stop_weight (req_stop_weight),
      .req_index       (req_index),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_status      (rsp_status)
   );

   `ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `ASSERT_IMPL(a_publish_slot_free, cmd.publish, !rsp_valid || rsp_ready)
   `ASSERT_ALWAYS(a_cmd_exclusive, $onehot0({cmd.clear, cmd.add, cmd.sum_step, cmd.publish}))
   `ASSERT_IMPL(a_add_not_full, cmd.add, !sts.full)

endmodule

`default_nettype wire

[bench/tb_weighted_gradient_palette_top.sv]
// ----------------------------------------------------------------------------
// Weighted gradient palette testbench
// Drives clear, add, lookup and unused-kind requests with random handshake
// gaps, predicts each result from a local copy of the stop table and palette
// size and checks every response field against the predicted one in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_weighted_gradient_palette_top;
   import wgp_pkg::*;

   localparam int STOP_LIMIT = 8;
   localparam int SIZE_LIMIT = 1024;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [1:0] status;
   } color_result_type;

   class palette_scoreboard;
      entry_type        stops[STOP_LIMIT];
      int               num_stops;
      int               size_setting;
      color_result_type pending[$];
      int               errors;

      function new();
         num_stops = 0;
         size_setting = 256;
         errors = 0;
      endfunction

      function automatic logic [7:0] mix(int c1, int c2, longint j, longint num, longint den);
         longint n;
         longint q;
         n = j * (c2 - c1) * num;
         q = n / den;
         if ((n % den) != 0 && n < 0) q--;
         return 8'((c1 + q) & 255);
      endfunction

      function void note_request(logic [1:0] kind, logic [7:0] r, logic [7:0] g,
                                 logic [7:0] b, logic [7:0] w, logic [9:0] idx);
         color_result_type res;
         longint sz, total, start, den, len, j;
         entry_type e1, e2;
         bit hit;
         res = '0;
         if (kind == KIND_CLEAR) begin
            num_stops = 0;
         end else if (kind == KIND_ADD) begin
            if (num_stops >= STOP_LIMIT) begin
               res.status = STATUS_FULL;
            end else begin
               stops[num_stops] = {r, g, b, w};
               num_stops++;
            end
         end else if (kind == KIND_LOOKUP) begin
            sz = (size_setting > SIZE_LIMIT) ? SIZE_LIMIT : size_setting;
            total = 0;
            for (int i = 0; i < num_stops; i++) total += stops[i].weight;
            if (num_stops < 2 || total == 0) begin
               res.status = STATUS_INVALID;
            end else begin
               start = 0;
               hit = 0;
               for (int i = 0; i < num_stops && !hit; i++) begin
                  e1 = stops[i];
                  e2 = stops[(i + 1 < num_stops) ? i + 1 : 0];
                  den = longint'(e1.weight) * sz;
                  len = den / total;
                  if (len > 0 && idx < start + len) begin
                     j = idx - start;
                     res.red = mix(e1.red, e2.red, j, total, den);
                     res.green = mix(e1.green, e2.green, j, total, den);
                     res.blue = mix(e1.blue, e2.blue, j, total, den);
                     hit = 1;
                  end
                  start += len;
               end
               if (!hit) res.status = STATUS_RANGE;
            end
         end
         pending.push_back(res);
      endfunction

      function void check_response(color_result_type got);
         color_result_type exp_res;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response, actual %h", $time, got);
            errors++;
            return;
         end
         exp_res = pending.pop_front();
         if (got.red !== exp_res.red) begin
            $display("%0t: red expected %0d actual %0d", $time, exp_res.red, got.red);
            errors++;
         end
         if (got.green !== exp_res.green) begin
            $display("%0t: green expected %0d actual %0d", $time, exp_res.green, got.green);
            errors++;
         end
         if (got.blue !== exp_res.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, exp_res.blue, got.blue);
            errors++;
         end
         if (got.status !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_res.status,
                     got.status);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_kind = KIND_CLEAR;
   logic [7:0]  req_red = 0, req_green = 0, req_blue = 0, req_stop_weight = 0;
   logic [9:0]  req_index = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [7:0]  rsp_out_red, rsp_out_green, rsp_out_blue;
   logic [1:0]  rsp_status;
   logic        csr_wr_en = 0;
   logic [10:0] csr_wr_data = 0;

   palette_scoreboard board = new();
   bit calm;

   weighted_gradient_palette_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue),
      .req_stop_weight(req_stop_weight), .req_index(req_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_red(rsp_out_red), .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue), .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_response({rsp_out_red, rsp_out_green, rsp_out_blue, rsp_status});
   end

   always @(negedge clock) begin
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 7);
   end

   task automatic send(logic [1:0] kind, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                       logic [7:0] w, logic [9:0] idx);
      while (!calm && $urandom_range(99) < 7) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      req_stop_weight <= w;
      req_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(kind, r, g, b, w, idx);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (5) @(negedge clock);
   endtask

   task automatic write_size(logic [10:0] value);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 0;
      board.size_setting = value;
   endtask

   task automatic add_random(int wmax);
      send(KIND_ADD, 8'($urandom), 8'($urandom), 8'($urandom),
           8'($urandom_range(wmax)), 10'($urandom));
   endtask

   task automatic random_lookup(int sz);
      logic [9:0] idx;
      idx = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(sz > 0 ? sz : 1));
      send(KIND_LOOKUP, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), idx);
   endtask

   initial begin
      int sz;
      int choice;
      logic [10:0] sizes[6];
      sizes = '{11'd2, 11'd1024, 11'd2047, 11'd37, 11'd0, 11'd1};
      calm = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      send(KIND_LOOKUP, 0, 0, 0, 0, 0);
      send(KIND_ADD, 8'hFF, 8'h00, 8'h80, 8'hFF, 0);
      send(KIND_LOOKUP, 0, 0, 0, 0, 0);
      send(KIND_ADD, 8'h00, 8'hFF, 8'h7F, 8'h01, 10'h3FF);
      send(KIND_LOOKUP, 0, 0, 0, 0, 0);
      send(KIND_LOOKUP, 0, 0, 0, 0, 10'd254);
      send(KIND_LOOKUP, 0, 0, 0, 0, 10'd255);
      send(KIND_LOOKUP, 0, 0, 0, 0, 10'h3FF);
      send(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 10'h3FF);
      send(KIND_CLEAR, 0, 0, 0, 0, 0);
      send(KIND_ADD, 8'd10, 8'd20, 8'd30, 0, 0);
      send(KIND_ADD, 8'd40, 8'd50, 8'd60, 0, 0);
      send(KIND_LOOKUP, 0, 0, 0, 0, 0);
      for (int i = 0; i < 7; i++) send(KIND_ADD, 8'(i * 30), 8'(255 - i), 8'(i), 8'(i), 0);
      send(KIND_LOOKUP, 0, 0, 0, 0, 10'd100);
      send(KIND_LOOKUP, 0, 0, 0, 0, 10'd5);

      for (int phase = 0; phase < 7; phase++) begin
         if (phase > 0) write_size(sizes[phase - 1]);
         calm = (phase == 3);
         sz = (board.size_setting > SIZE_LIMIT) ? SIZE_LIMIT : board.size_setting;
         for (int k = 0; k < 160; k++) begin
            choice = $urandom_range(99);
            if (choice < 8) begin
               send(KIND_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    10'($urandom));
               repeat ($urandom_range(8, 2)) add_random((choice < 2) ? 3 : 255);
            end else if (choice < 14) begin
               add_random(255);
            end else if (choice < 16) begin
               send(KIND_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    10'($urandom));
            end else begin
               random_lookup(sz);
            end
            if (k == 100 && phase == 1) drain();
         end
      end
      calm = 0;
      drain();
      repeat (20) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

endmodule
